@@ rtl/bri_pkg.sv @@
package bri_pkg;

	localparam int U_W   = 18;
	localparam int V_W   = 24;
	localparam int D_W   = 28;
	localparam int S_W   = 20;
	localparam int T_W   = 36;
	localparam int Q_W   = 39;
	localparam int SUM_W = 41;
	localparam int ADDR_W = 3;
	localparam int NSTEP = 4;

	localparam logic signed [T_W-1:0] T_LIM   = 36'sh7_FFFF_FFFF;
	localparam logic signed [V_W-1:0] OUT_LIM = 24'sh7F_FFFF;
	localparam logic [Q_W-1:0]        X_CAP   = {Q_W{1'b1}};
	// ceil(2^40 / 3); exact floor division by three for any value below 2^39.
	localparam logic [Q_W-1:0]        RECIP3  = 39'h55_5555_5556;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_FIVE_KNOTS = 1'b0;

	typedef struct packed {
		logic                       five;
		logic signed [S_W-1:0]      s;
		logic [3:0][D_W-1:0]        d;
		logic                       hit;
		logic signed [V_W-1:0]      hv;
	} ctx_t;

endpackage

@@ rtl/barycentric_rational_interp.sv @@
// Evaluates the barycentric rational interpolant of order knots-1 through three knots
// (0, 0.5, 1) or five knots (quarter spaced) on [0,1], which equals the interpolating
// polynomial; it is computed in Newton forward-difference form and saturated to Q8.16.
// An item enters every cycle; each input beat passes through one entry stage, four
// Horner steps of five stages each and one output register to its result, and
// a stall on the result side holds the whole pipeline. five_knots is written through
// the APB port at byte address 0 and must only change while the pipeline is empty.
module barycentric_rational_interp import bri_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic signed [U_W-1:0]   u,
	input  logic signed [V_W-1:0]   value_0,
	input  logic signed [V_W-1:0]   value_1,
	input  logic signed [V_W-1:0]   value_2,
	input  logic signed [V_W-1:0]   value_3,
	input  logic signed [V_W-1:0]   value_4,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic signed [V_W-1:0]   result
);

	localparam int FW = ((FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19) + 2;
	localparam int PW = FW + T_W;
	localparam int KW = ((FRAC_BITS + 1 > U_W) ? FRAC_BITS + 1 : U_W) + 1;
	localparam int RW = PW + 1;
	localparam int XW = RW - FRAC_BITS;

	logic five_q;
	logic en;

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			five_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_FIVE_KNOTS) begin
			five_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[ADDR_W-1] == REG_FIVE_KNOTS) ? {31'b0, five_q} : 32'b0;

	logic out_vld_q;
	assign en           = ~out_vld_q | result_ready;
	assign item_ready   = en;

	// Entry stage: differences, scaled parameter, exact knot match.
	logic signed [D_W-1:0] e0, e1, e2, e3, e4;
	logic signed [D_W-1:0] d1, d2, d3, d4;
	logic signed [KW-1:0]  u_w;
	logic                  hit_c;
	logic signed [V_W-1:0] hv_c;
	logic [4:0][V_W-1:0]   vals;

	always_comb begin
		logic signed [KW-1:0] knot;
		e0 = D_W'(value_0);
		e1 = D_W'(value_1);
		e2 = D_W'(value_2);
		e3 = D_W'(value_3);
		e4 = D_W'(value_4);
		d1 = e1 - e0;
		d2 = e2 - (e1 <<< 1) + e0;
		d3 = e3 - (e2 + (e2 <<< 1)) + (e1 + (e1 <<< 1)) - e0;
		d4 = e4 - (e3 <<< 2) + ((e2 <<< 2) + (e2 <<< 1)) - (e1 <<< 2) + e0;
		vals = {value_4, value_3, value_2, value_1, value_0};
		u_w  = KW'(u);
		hit_c = 1'b0;
		hv_c  = value_0;
		for (int i = 4; i >= 0; i--) begin
			knot = five_q ? (KW'(i) << (FRAC_BITS - 2)) : (KW'(i) << (FRAC_BITS - 1));
			if ((five_q || i < 3) && u_w == knot) begin
				hit_c = 1'b1;
				hv_c  = vals[i];
			end
		end
	end

	logic                  vld_s0;
	ctx_t                  ctx_s0;
	logic signed [T_W-1:0] t_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s0.five <= five_q;
			ctx_s0.s    <= five_q ? (S_W'(u) <<< 2) : (S_W'(u) <<< 1);
			ctx_s0.d    <= {d3, d2, d1, e0};
			ctx_s0.hit  <= hit_c;
			ctx_s0.hv   <= hv_c;
			t_s0        <= five_q ? T_W'(d4) : T_W'(d2);
		end
	end

	logic                  vld_ch [NSTEP+1];
	ctx_t                  ctx_ch [NSTEP+1];
	logic signed [T_W-1:0] t_ch   [NSTEP+1];

	assign vld_ch[0] = vld_s0;
	assign ctx_ch[0] = ctx_s0;
	assign t_ch[0]   = t_s0;

	// Horner steps for k = 3, 2, 1, 0; the first two are bypassed with three knots.
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int K = NSTEP - 1 - j;
		localparam logic signed [FW-1:0] KOFF = FW'(longint'(K) << FRAC_BITS);
		localparam logic [RW-1:0] HALF    = RW'(longint'(K + 1) << (FRAC_BITS - 1));
		localparam logic [RW-1:0] HALF_P1 = HALF + RW'(1);

		logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
		ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
		logic signed [T_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
		logic signed [PW-1:0]  prod_s1;
		logic                  neg_s2, neg_s3, neg_s4;
		logic [Q_W-1:0]        x_s2, q_s4;
		logic [Q_W-1:0]        xd_s3;
		logic [37:0]           hh_s3;
		logic [38:0]           hl_s3, lh_s3;
		logic [39:0]           ll_s3;

		logic signed [FW-1:0]  f_c;
		logic [RW-1:0]         rnd_c;
		logic [XW-1:0]         xs_c;
		logic [78:0]           sum3_c;
		logic signed [SUM_W-1:0] acc_c;
		logic signed [SUM_W-1:0] a_c;
		logic signed [SUM_W-1:0] qv_c;
		logic                  act_c;

		always_comb begin
			f_c   = FW'(ctx_ch[j].s) - KOFF;
			rnd_c = (prod_s1[PW-1] ? {1'b0, ~prod_s1} : {1'b0, prod_s1})
				+ (prod_s1[PW-1] ? HALF_P1 : HALF);
			xs_c  = rnd_c[RW-1:FRAC_BITS];
			sum3_c = ({41'b0, hh_s3} << 40) + ({40'b0, hl_s3} << 20)
				+ ({40'b0, lh_s3} << 20) + {39'b0, ll_s3};
			act_c = (K < 2) || ctx_s4.five;
			a_c   = SUM_W'($signed(ctx_s4.d[K]));
			qv_c  = $signed({2'b0, q_s4});
			acc_c = neg_s4 ? (a_c - qv_c) : (a_c + qv_c);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				vld_s3 <= 1'b0;
				vld_s4 <= 1'b0;
				vld_s5 <= 1'b0;
			end else if (en) begin
				vld_s1 <= vld_ch[j];
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s1  <= ctx_ch[j];
				t_s1    <= t_ch[j];
				prod_s1 <= PW'(f_c) * PW'(t_ch[j]);

				ctx_s2 <= ctx_s1;
				t_s2   <= t_s1;
				neg_s2 <= prod_s1[PW-1];
				// Anything this large saturates the step anyway.
				x_s2   <= (xs_c > XW'(X_CAP)) ? X_CAP : Q_W'(xs_c);

				ctx_s3 <= ctx_s2;
				t_s3   <= t_s2;
				neg_s3 <= neg_s2;
				xd_s3  <= x_s2 >> ((K == 3) ? 2 : (K == 1) ? 1 : 0);
				hh_s3  <= x_s2[38:20] * RECIP3[38:20];
				hl_s3  <= x_s2[38:20] * RECIP3[19:0];
				lh_s3  <= x_s2[19:0] * RECIP3[38:20];
				ll_s3  <= x_s2[19:0] * RECIP3[19:0];

				ctx_s4 <= ctx_s3;
				t_s4   <= t_s3;
				neg_s4 <= neg_s3;
				q_s4   <= (K == 2) ? sum3_c[78:40] : xd_s3;

				ctx_s5 <= ctx_s4;
				if (!act_c) begin
					t_s5 <= t_s4;
				end else if (acc_c > SUM_W'(T_LIM)) begin
					t_s5 <= T_LIM;
				end else if (acc_c < -SUM_W'(T_LIM)) begin
					t_s5 <= -T_LIM;
				end else begin
					t_s5 <= T_W'(acc_c);
				end
			end
		end

		assign vld_ch[j+1] = vld_s5;
		assign ctx_ch[j+1] = ctx_s5;
		assign t_ch[j+1]   = t_s5;
	end

	// Output register.
	logic signed [V_W-1:0] result_q;
	logic                  out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_ch[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q <= ctx_ch[NSTEP].hit;
			if (ctx_ch[NSTEP].hit) begin
				result_q <= ctx_ch[NSTEP].hv;
			end else if (t_ch[NSTEP] > T_W'(OUT_LIM)) begin
				result_q <= OUT_LIM;
			end else if (t_ch[NSTEP] < -T_W'(OUT_LIM)) begin
				result_q <= -OUT_LIM;
			end else begin
				result_q <= V_W'(t_ch[NSTEP]);
			end
		end
	end

	assign result_valid = out_vld_q;
	assign result       = result_q;

	a_sym_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result == 24'sh80_0000) |-> out_hit_q)
		else $error("saturated result reached the negative limit");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_ch[NSTEP]) |=> result_valid)
		else $error("beat lost between last step and output register");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_ch[NSTEP] |-> (t_ch[NSTEP] <= T_LIM && t_ch[NSTEP] >= -T_LIM))
		else $error("Horner accumulator outside its saturation range");

endmodule
